@@ rtl/core/sme_pkg.sv @@
`default_nettype none
package sme_pkg;
   localparam int DataStackDepthDef   = 64;
   localparam int ReturnStackDepthDef = 16;
   localparam int RegisterCountDef    = 4;
   localparam int MemoryWordsDef      = 1024;
   localparam int ProgramWordsDef     = 4096;

   localparam int OpW     = 5;
   localparam int WordW   = 32;
   localparam int AddrW   = 12;
   localparam int RegIdxW = 2;

   localparam logic [4:0] OP_HLT  = 5'd0;
   localparam logic [4:0] OP_JMP  = 5'd1;
   localparam logic [4:0] OP_JA   = 5'd2;
   localparam logic [4:0] OP_JAE  = 5'd3;
   localparam logic [4:0] OP_JB   = 5'd4;
   localparam logic [4:0] OP_JBE  = 5'd5;
   localparam logic [4:0] OP_JE   = 5'd6;
   localparam logic [4:0] OP_JNE  = 5'd7;
   localparam logic [4:0] OP_IN   = 5'd8;
   localparam logic [4:0] OP_OUT  = 5'd9;
   localparam logic [4:0] OP_OUTC = 5'd10;
   localparam logic [4:0] OP_ADD  = 5'd11;
   localparam logic [4:0] OP_SUB  = 5'd12;
   localparam logic [4:0] OP_DIV  = 5'd13;
   localparam logic [4:0] OP_MULT = 5'd14;
   localparam logic [4:0] OP_LBL  = 5'd15;
   localparam logic [4:0] OP_CALL = 5'd16;
   localparam logic [4:0] OP_RET  = 5'd17;
   localparam logic [4:0] OP_PP   = 5'd18;

   localparam logic [2:0] ERR_OK   = 3'd0;
   localparam logic [2:0] ERR_OPC  = 3'd1;
   localparam logic [2:0] ERR_UND  = 3'd2;
   localparam logic [2:0] ERR_OVF  = 3'd3;
   localparam logic [2:0] ERR_DIV0 = 3'd4;
   localparam logic [2:0] ERR_ADDR = 3'd5;

   localparam logic [1:0] PK_NONE = 2'd0;
   localparam logic [1:0] PK_DEC  = 2'd1;
   localparam logic [1:0] PK_CHR  = 2'd2;

   typedef struct packed {
      logic [4:0]  operation;
      logic        is_pop;
      logic        use_memory;
      logic        use_register;
      logic        use_immediate;
      logic [1:0]  register_index;
      logic [31:0] immediate;
      logic [11:0] target;
      logic [31:0] input_value;
   } instr_type;
endpackage
`default_nettype wire

@@ rtl/core/stack_machine_executor_core.sv @@
// Executes one decoded stack-machine instruction per request word.
// Request channel: req_valid with req_stall; the fields are the decoded
// instruction and the value for the in instruction. Response channel:
// rsp_valid with rsp_stall returns one word per request: next fetch address,
// print kind and value, halted and error code.
// A two-word queue takes requests while the execute side is busy.
// Each accepted request is queued, then its operands are read from the
// stack memories, then it executes into the response register; mult takes
// an extra multiply step and div runs a one-bit-per-cycle divider.
// The next instruction enters in the cycle its predecessor's response word
// leaves.
// After reset the data RAM is cleared word by word before the first
// instruction executes; requests still queue in that time.
// A stalled response holds and blocks further execution; the queue then
// fills and raises req_stall.
`default_nettype none
module stack_machine_executor_core
   import sme_pkg::*;
#(
   parameter int DATA_STACK_DEPTH   = DataStackDepthDef,
   parameter int RETURN_STACK_DEPTH = ReturnStackDepthDef,
   parameter int REGISTER_COUNT     = RegisterCountDef,
   parameter int MEMORY_WORDS       = MemoryWordsDef,
   parameter int PROGRAM_WORDS      = ProgramWordsDef
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_operation,
   input  wire logic        req_is_pop,
   input  wire logic        req_use_memory,
   input  wire logic        req_use_register,
   input  wire logic        req_use_immediate,
   input  wire logic [1:0]  req_register_index,
   input  wire logic [31:0] req_immediate,
   input  wire logic [11:0] req_target,
   input  wire logic [31:0] req_input_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_next_address,
   output logic [1:0]       rsp_print_kind,
   output logic [31:0]      rsp_print_value,
   output logic             rsp_halted,
   output logic [2:0]       rsp_error_code
);
   instr_type req_word, q_word;
   logic      q_valid, q_take;

   always_comb begin
      req_word.operation      = req_operation;
      req_word.is_pop         = req_is_pop;
      req_word.use_memory     = req_use_memory;
      req_word.use_register   = req_use_register;
      req_word.use_immediate  = req_use_immediate;
      req_word.register_index = req_register_index;
      req_word.immediate      = req_immediate;
      req_word.target         = req_target;
      req_word.input_value    = req_input_value;
   end

   sme_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_word(req_word), .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
   );

   sme_back #(
      .DATA_STACK_DEPTH(DATA_STACK_DEPTH), .RETURN_STACK_DEPTH(RETURN_STACK_DEPTH),
      .REGISTER_COUNT(REGISTER_COUNT), .MEMORY_WORDS(MEMORY_WORDS),
      .PROGRAM_WORDS(PROGRAM_WORDS)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_word(q_word), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_next_address(rsp_next_address), .rsp_print_kind(rsp_print_kind),
      .rsp_print_value(rsp_print_value), .rsp_halted(rsp_halted),
      .rsp_error_code(rsp_error_code)
   );
endmodule
`default_nettype wire

@@ rtl/core/sme_front.sv @@
`default_nettype none
module sme_front
   import sme_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire instr_type req_word,
   output logic           q_valid,
   input  wire logic      q_take,
   output instr_type      q_word
);
   // Two-entry queue between acceptance and execution.
   instr_type  mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_word    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= req_word;
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |=> cnt_ff == 2'd2)
      else $error("full queue lost a word");
   a_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointers disagree with count");
`endif
endmodule
`default_nettype wire

@@ rtl/core/sme_divider.sv @@
`default_nettype none
module sme_divider
   import sme_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WordW-1:0]  dividend,
   input  wire logic [WordW-1:0]  divisor,
   output logic                   done,
   output logic [WordW-1:0]       quotient
);
   // Restoring division on magnitudes, one bit a cycle; sign fixed at the end.
   logic              busy_ff, busy_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [WordW-1:0]  q_ff, q_in, d_ff, d_in;
   logic [WordW:0]    r_ff, r_in, trial;
   logic              neg_ff, neg_in, done_ff, done_in;
   logic [WordW-1:0]  mag_a, mag_b;

   assign mag_a = dividend[WordW-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b = divisor[WordW-1] ? (~divisor + 1'b1) : divisor;
   assign trial = {r_ff[WordW-1:0], q_ff[WordW-1]} - {1'b0, d_ff};
   assign done = done_ff;
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(WordW);
         q_in    = mag_a;
         d_in    = mag_b;
         r_in    = '0;
         neg_in  = dividend[WordW-1] ^ divisor[WordW-1];
      end else if (busy_ff) begin
         if (trial[WordW]) begin
            r_in = {r_ff[WordW-1:0], q_ff[WordW-1]};
            q_in = {q_ff[WordW-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[WordW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

@@ rtl/core/sme_back.sv @@
`default_nettype none
module sme_back
   import sme_pkg::*;
#(
   parameter int DATA_STACK_DEPTH   = DataStackDepthDef,
   parameter int RETURN_STACK_DEPTH = ReturnStackDepthDef,
   parameter int REGISTER_COUNT     = RegisterCountDef,
   parameter int MEMORY_WORDS       = MemoryWordsDef,
   parameter int PROGRAM_WORDS      = ProgramWordsDef
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_take,
   input  wire instr_type   q_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_next_address,
   output logic [1:0]       rsp_print_kind,
   output logic [31:0]      rsp_print_value,
   output logic             rsp_halted,
   output logic [2:0]       rsp_error_code
);
   localparam int DsW = $clog2(DATA_STACK_DEPTH);
   localparam int RsW = $clog2(RETURN_STACK_DEPTH);
   localparam int MaW = $clog2(MEMORY_WORDS);
   localparam int RcW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RUN   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;

   // Sequential program addresses wrap at the end of the program space.
   function automatic logic [11:0] pc_add(logic [11:0] base, logic [1:0] inc);
      logic [12:0] s;
      s = {1'b0, base} + {11'd0, inc};
      if (s >= 13'(PROGRAM_WORDS)) s = s - 13'(PROGRAM_WORDS);
      return s[11:0];
   endfunction

   logic [2:0]  st_ff, st_in;
   instr_type   ins_ff;
   logic [DsW:0] dd_ff, dd_in;
   logic [RsW:0] rd_ff, rd_in;
   logic [11:0] ip_ff, ip_in;
   logic        stop_ff, stop_in;
   logic [MaW:0] clr_ff, clr_in;
   logic [31:0] regs_ff [REGISTER_COUNT];

   logic [31:0] ds_mem [DATA_STACK_DEPTH];
   logic [11:0] rs_mem [RETURN_STACK_DEPTH];
   logic [31:0] dm_mem [MEMORY_WORDS];

   // Registered reads: top, next, return top, RAM word.
   logic [31:0] top_ff, nxt_ff, ram_ff, mul_ff;
   logic [11:0] rtop_ff;

   logic        ov_ff, ov_in;
   logic [1:0]  ok_ff, ok_in;
   logic [31:0] ov_pv_ff, ov_pv_in;
   logic [11:0] ov_na_ff, ov_na_in;
   logic        ov_h_ff, ov_h_in;
   logic [2:0]  ov_e_ff, ov_e_in;

   logic        div_start, div_done;
   logic [31:0] div_q;

   sme_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(top_ff), .divisor(nxt_ff), .done(div_done), .quotient(div_q)
   );

   // Combinational decode of the current instruction.
   logic [31:0] regv, sum, wval, res;
   logic        ri_bad, addr_bad, tgt_bad, take, is_j, is_ar;
   logic [2:0]  err;
   logic [11:0] nxt;
   logic [1:0]  words;
   logic        ds_we, rs_we, dm_we, reg_we;
   logic [DsW-1:0] ds_wa;
   logic [31:0] ds_wd;
   logic        fin;
   logic signed [31:0] sx, sy;
   logic        run_ok;

   // A response word that leaves in this cycle frees the output register, so
   // the next instruction may enter at the same edge.
   assign run_ok = (st_ff == S_IDLE) && (!ov_ff || !rsp_stall);
   assign q_take = run_ok;
   assign rsp_valid = ov_ff;
   assign rsp_next_address = ov_na_ff;
   assign rsp_print_kind = ok_ff;
   assign rsp_print_value = ov_pv_ff;
   assign rsp_halted = ov_h_ff;
   assign rsp_error_code = ov_e_ff;

   always_comb begin
      regv = (ins_ff.register_index < REGISTER_COUNT)
         ? regs_ff[RcW'(ins_ff.register_index)] : 32'd0;
      ri_bad = ins_ff.use_register && (ins_ff.register_index >= REGISTER_COUNT);
      sum = (ins_ff.use_register ? regv : 32'd0)
          + ((ins_ff.use_immediate && (ins_ff.use_memory || !ins_ff.is_pop))
             ? ins_ff.immediate : 32'd0);
      words = 2'd1 + {1'b0, ins_ff.use_register}
            + {1'b0, ins_ff.use_immediate && (ins_ff.use_memory || !ins_ff.is_pop)};
      addr_bad = ins_ff.use_memory && (sum >= MEMORY_WORDS);
      tgt_bad = 32'(ins_ff.target) >= PROGRAM_WORDS;
      sx = top_ff;
      sy = nxt_ff;
      is_j = (ins_ff.operation >= OP_JA) && (ins_ff.operation <= OP_JNE);
      is_ar = (ins_ff.operation >= OP_ADD) && (ins_ff.operation <= OP_MULT);
      unique case (ins_ff.operation)
         OP_JA:   take = sx > sy;
         OP_JAE:  take = sx >= sy;
         OP_JB:   take = sx < sy;
         OP_JBE:  take = sx <= sy;
         OP_JE:   take = sx == sy;
         default: take = sx != sy;
      endcase
      err = ERR_OK;
      if (ins_ff.operation > OP_PP) err = ERR_OPC;
      else if ((ins_ff.operation == OP_JMP || is_j || ins_ff.operation == OP_CALL)
               && tgt_bad) err = ERR_ADDR;
      else if (is_j && dd_ff < 2) err = ERR_UND;
      else if (ins_ff.operation == OP_IN && dd_ff >= DATA_STACK_DEPTH) err = ERR_OVF;
      else if ((ins_ff.operation == OP_OUT || ins_ff.operation == OP_OUTC)
               && dd_ff == 0) err = ERR_UND;
      else if (is_ar && dd_ff < 2) err = ERR_UND;
      else if (ins_ff.operation == OP_DIV && nxt_ff == 32'd0) err = ERR_DIV0;
      else if (ins_ff.operation == OP_CALL && rd_ff >= RETURN_STACK_DEPTH) err = ERR_OVF;
      else if (ins_ff.operation == OP_RET && rd_ff == 0) err = ERR_UND;
      else if (ins_ff.operation == OP_PP) begin
         if (ri_bad || addr_bad) err = ERR_ADDR;
         else if (!ins_ff.is_pop && dd_ff >= DATA_STACK_DEPTH) err = ERR_OVF;
         else if (ins_ff.is_pop && dd_ff == 0) err = ERR_UND;
      end
      wval = ins_ff.use_memory ? ram_ff : sum;
      unique case (ins_ff.operation)
         OP_ADD:  res = top_ff + nxt_ff;
         OP_SUB:  res = top_ff - nxt_ff;
         OP_DIV:  res = div_q;
         default: res = mul_ff;
      endcase
      nxt = pc_add(ip_ff, 2'd1);
      unique case (ins_ff.operation)
         OP_JMP, OP_CALL: nxt = ins_ff.target;
         OP_RET:  nxt = rtop_ff;
         OP_PP:   nxt = pc_add(ip_ff, words);
         default: if (is_j) nxt = take ? ins_ff.target : pc_add(ip_ff, 2'd2);
      endcase
   end

   // Steps the RAM clear and the idle state; executes in S_RUN (or finishing S_DIV/S_MUL).
   always_comb begin
      st_in = st_ff;
      dd_in = dd_ff;
      rd_in = rd_ff;
      ip_in = ip_ff;
      stop_in = stop_ff;
      clr_in = clr_ff;
      ov_in = ov_ff && rsp_stall;
      ok_in = ok_ff; ov_pv_in = ov_pv_ff; ov_na_in = ov_na_ff;
      ov_h_in = ov_h_ff; ov_e_in = ov_e_ff;
      ds_we = 1'b0; rs_we = 1'b0; dm_we = 1'b0; reg_we = 1'b0;
      ds_wa = dd_ff[DsW-1:0];
      ds_wd = ins_ff.input_value;
      div_start = 1'b0;
      fin = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (MaW+1)'(MEMORY_WORDS - 1)) st_in = S_IDLE;
         end
         S_IDLE: if (q_valid && run_ok) st_in = S_RUN;
         S_DIV: if (div_done) fin = 1'b1;
         S_MUL: fin = 1'b1;
         default: begin
            if (stop_ff || err != ERR_OK) fin = 1'b1;
            else if (ins_ff.operation == OP_DIV) begin
               div_start = 1'b1;
               st_in = S_DIV;
            end else if (ins_ff.operation == OP_MULT) st_in = S_MUL;
            else fin = 1'b1;
         end
      endcase
      if (fin) begin
         st_in = S_IDLE;
         ov_in = 1'b1;
         ok_in = PK_NONE; ov_pv_in = 32'd0; ov_e_in = ERR_OK;
         if (stop_ff) begin
            ov_na_in = ip_ff; ov_h_in = 1'b1;
         end else if (err != ERR_OK) begin
            ov_na_in = ip_ff; ov_h_in = 1'b1; ov_e_in = err; stop_in = 1'b1;
         end else begin
            ov_na_in = nxt; ov_h_in = 1'b0; ip_in = nxt;
            priority case (1'b1)
               ins_ff.operation == OP_HLT: begin
                  ov_na_in = ip_ff; ip_in = ip_ff; ov_h_in = 1'b1; stop_in = 1'b1;
               end
               is_j: dd_in = dd_ff - 2'd2;
               ins_ff.operation == OP_IN: begin
                  ds_we = 1'b1; dd_in = dd_ff + 1'b1;
               end
               ins_ff.operation == OP_OUT || ins_ff.operation == OP_OUTC: begin
                  dd_in = dd_ff - 1'b1; ov_pv_in = top_ff;
                  ok_in = (ins_ff.operation == OP_OUT) ? PK_DEC : PK_CHR;
               end
               is_ar: begin
                  ds_we = 1'b1; ds_wa = DsW'(dd_ff - 2'd2); ds_wd = res;
                  dd_in = dd_ff - 1'b1;
               end
               ins_ff.operation == OP_CALL: begin
                  rs_we = 1'b1; rd_in = rd_ff + 1'b1;
               end
               ins_ff.operation == OP_RET: rd_in = rd_ff - 1'b1;
               ins_ff.operation == OP_PP: begin
                  if (!ins_ff.is_pop) begin
                     ds_we = 1'b1; ds_wd = wval; dd_in = dd_ff + 1'b1;
                  end else begin
                     dd_in = dd_ff - 1'b1;
                     if (ins_ff.use_memory) dm_we = 1'b1;
                     else if (ins_ff.use_register) reg_we = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Read addresses use the state that holds when the next item enters.
   logic [DsW:0] rd_dd;
   logic [RsW:0] rd_rd;
   logic [31:0]  pre_sum, pre_reg;
   instr_type    qi;
   always_comb begin
      qi = q_word;
      rd_dd = dd_ff;
      rd_rd = rd_ff;
      pre_reg = (qi.register_index < REGISTER_COUNT)
         ? regs_ff[RcW'(qi.register_index)] : 32'd0;
      pre_sum = (qi.use_register ? pre_reg : 32'd0)
              + (qi.use_immediate ? qi.immediate : 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         dd_ff <= '0; rd_ff <= '0; ip_ff <= '0;
         stop_ff <= 1'b0; clr_ff <= '0; ov_ff <= 1'b0;
         for (int i = 0; i < REGISTER_COUNT; i++) regs_ff[i] <= 32'd0;
      end else begin
         st_ff <= st_in; dd_ff <= dd_in; rd_ff <= rd_in; ip_ff <= ip_in;
         stop_ff <= stop_in; clr_ff <= clr_in; ov_ff <= ov_in;
         if (reg_we) regs_ff[RcW'(ins_ff.register_index)] <= top_ff;
      end
      ok_ff <= ok_in; ov_pv_ff <= ov_pv_in; ov_na_ff <= ov_na_in;
      ov_h_ff <= ov_h_in; ov_e_ff <= ov_e_in;
      mul_ff <= top_ff * nxt_ff;
      if (run_ok && q_valid) begin
         ins_ff <= q_word;
         top_ff <= ds_mem[DsW'(rd_dd - 1'b1)];
         nxt_ff <= ds_mem[DsW'(rd_dd - 2'd2)];
         rtop_ff <= rs_mem[RsW'(rd_rd - 1'b1)];
         ram_ff <= dm_mem[MaW'(pre_sum)];
      end
   end

   always_ff @(posedge clock) begin
      if (ds_we) ds_mem[ds_wa] <= ds_wd;
   end
   always_ff @(posedge clock) begin
      if (rs_we) rs_mem[rd_ff[RsW-1:0]] <= pc_add(ip_ff, 2'd2);
   end
   always_ff @(posedge clock) begin
      if (st_ff == S_CLEAR) dm_mem[clr_ff[MaW-1:0]] <= 32'd0;
      else if (dm_we) dm_mem[sum[MaW-1:0]] <= top_ff;
   end

`ifndef SYNTHESIS
   a_dd: assert property (@(posedge clock) disable iff (reset)
      dd_ff <= DATA_STACK_DEPTH) else $error("data depth overrun");
   a_rd: assert property (@(posedge clock) disable iff (reset)
      rd_ff <= RETURN_STACK_DEPTH) else $error("return depth overrun");
   a_err_halt: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ov_e_ff != ERR_OK |-> ov_h_ff) else $error("error without halt");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && rsp_stall |=> ov_ff && $stable(ov_na_ff))
      else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
